// File: rtl/midi_running_status_parser_core_assert.svh
// Assertion macros shared by the parser RTL.
`ifndef MIDI_RUNNING_STATUS_PARSER_CORE_ASSERT_SVH
`define MIDI_RUNNING_STATUS_PARSER_CORE_ASSERT_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define MRSP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// Next-cycle implication, checked at every rising edge out of reset.
`define MRSP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

// File: rtl/mrsp_pkg.sv
// ----------------------------------------------------------------------------
// MIDI running-status parser package
// Word types for the byte and message channels, and the status constants.
// ----------------------------------------------------------------------------
package mrsp_pkg;

    localparam logic [7:0] STATUS_BIT    = 8'h80;
    localparam logic [3:0] SYSTEM_NIBBLE = 4'hF;
    localparam logic [3:0] PROGRAM_KIND  = 4'hC;
    localparam logic [3:0] PRESSURE_KIND = 4'hD;
    localparam logic [1:0] ONE_ARG       = 2'd1;
    localparam logic [1:0] TWO_ARGS      = 2'd2;

    typedef struct packed {
        logic [7:0]  rx_byte;
        logic [31:0] time_now;
    } byte_word_t;

    typedef struct packed {
        logic [3:0]  msg_kind;
        logic [3:0]  msg_channel;
        logic [6:0]  first_data;
        logic [6:0]  second_data;
        logic [13:0] bend_value;
        logic [31:0] delta_ticks;
    } msg_word_t;

endpackage

// File: rtl/midi_running_status_parser_core.sv
// Path: a byte taken into the input register yields its message word in the output register.
// Throughput: one byte per cycle; a byte that completes a message waits in the
// input register only while the previous message word is stalled.
// Reset: asynchronous, active low; clears the running status, the held data,
// the last message time and both valid flags, and sets the argument count to two.
// ----------------------------------------------------------------------------
// MIDI running-status parser core
// Parses channel messages from received bytes and emits one word per message.
// ----------------------------------------------------------------------------
`include "midi_running_status_parser_core_assert.svh"

module midi_running_status_parser_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 byte_valid,
    output logic                 byte_stall,
    input  mrsp_pkg::byte_word_t byte_word,
    output logic                 msg_valid,
    input  logic                 msg_stall,
    output mrsp_pkg::msg_word_t  msg_word
);

    logic                 item_valid_reg;
    mrsp_pkg::byte_word_t item_reg;
    logic                 out_valid_reg;
    mrsp_pkg::msg_word_t  out_reg;

    logic [7:0]  running_status_reg, running_status_next;
    logic [6:0]  held_first_reg, held_first_next;
    logic [6:0]  held_second_reg, held_second_next;
    logic [1:0]  args_needed_reg, args_needed_next;
    logic [1:0]  args_remaining_reg, args_remaining_next;
    logic        have_status_reg, have_status_next;
    logic [31:0] last_msg_time_reg, last_msg_time_next;

    logic        emit;
    logic        advance;
    logic        item_fire;
    logic [7:0]  b;
    logic [1:0]  remaining_step;
    mrsp_pkg::msg_word_t result;

    assign b = item_reg.rx_byte;

    always_comb
    begin
        running_status_next = running_status_reg;
        held_first_next     = held_first_reg;
        held_second_next    = held_second_reg;
        args_needed_next    = args_needed_reg;
        args_remaining_next = args_remaining_reg;
        have_status_next    = have_status_reg;
        last_msg_time_next  = last_msg_time_reg;
        remaining_step      = args_remaining_reg;
        emit                = 1'b0;

        if ((b & mrsp_pkg::STATUS_BIT) != 8'd0)
        begin
            if (b[7:4] != mrsp_pkg::SYSTEM_NIBBLE)
            begin
                running_status_next = b;
                if (b[7:4] == mrsp_pkg::PROGRAM_KIND || b[7:4] == mrsp_pkg::PRESSURE_KIND)
                begin
                    args_needed_next = mrsp_pkg::ONE_ARG;
                end
                else
                begin
                    args_needed_next = mrsp_pkg::TWO_ARGS;
                end
                args_remaining_next = args_needed_next;
                held_first_next     = 7'd0;
                held_second_next    = 7'd0;
                have_status_next    = 1'b1;
            end
        end
        else if (have_status_reg)
        begin
            if (args_remaining_reg == args_needed_reg || args_remaining_reg == 2'd0)
            begin
                held_first_next = b[6:0];
                remaining_step  = args_needed_reg - 2'd1;
            end
            else
            begin
                held_second_next = b[6:0];
                remaining_step   = args_remaining_reg - 2'd1;
            end
            args_remaining_next = remaining_step;
            if (remaining_step == 2'd0)
            begin
                emit                = 1'b1;
                args_remaining_next = args_needed_reg;
                last_msg_time_next  = item_reg.time_now;
            end
        end

        result.msg_kind    = running_status_reg[7:4];
        result.msg_channel = running_status_reg[3:0];
        result.first_data  = held_first_next;
        result.second_data = held_second_next;
        result.bend_value  = {held_second_next, held_first_next};
        result.delta_ticks = item_reg.time_now - last_msg_time_reg;
    end

    assign advance    = !out_valid_reg || !msg_stall;
    assign item_fire  = item_valid_reg && (advance || !emit);
    assign byte_stall = item_valid_reg && !item_fire;
    assign msg_valid  = out_valid_reg;
    assign msg_word   = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg     <= 1'b0;
            out_valid_reg      <= 1'b0;
            running_status_reg <= 8'd0;
            held_first_reg     <= 7'd0;
            held_second_reg    <= 7'd0;
            args_needed_reg    <= mrsp_pkg::TWO_ARGS;
            args_remaining_reg <= 2'd0;
            have_status_reg    <= 1'b0;
            last_msg_time_reg  <= 32'd0;
        end
        else
        begin
            if (!byte_stall)
            begin
                item_valid_reg <= byte_valid;
            end
            if (advance)
            begin
                out_valid_reg <= item_valid_reg && emit;
            end
            if (item_fire)
            begin
                running_status_reg <= running_status_next;
                held_first_reg     <= held_first_next;
                held_second_reg    <= held_second_next;
                args_needed_reg    <= args_needed_next;
                args_remaining_reg <= args_remaining_next;
                have_status_reg    <= have_status_next;
                last_msg_time_reg  <= last_msg_time_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid && !byte_stall)
        begin
            item_reg <= byte_word;
        end
        if (advance && item_valid_reg && emit)
        begin
            out_reg <= result;
        end
    end

    `MRSP_ASSERT_NOW(a_remaining_bounded, 1'b1, args_remaining_reg <= args_needed_reg)
    `MRSP_ASSERT_NOW(a_needed_legal, 1'b1,
        args_needed_reg == mrsp_pkg::ONE_ARG || args_needed_reg == mrsp_pkg::TWO_ARGS)
    `MRSP_ASSERT_NOW(a_msg_has_status, msg_valid, have_status_reg && msg_word.msg_kind[3])
    `MRSP_ASSERT_NEXT(a_emit_records_time, item_fire && emit,
        out_valid_reg && last_msg_time_reg == $past(item_reg.time_now))

endmodule
